// ===== design/dgc_pkg.sv =====
// dgc_pkg: shared widths, calendar constants and helper functions for the date converter
`timescale 1ns / 1ps
`default_nettype none

package dgc_pkg;

  // port field widths
  localparam int DAY_W   = 22;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;

  localparam int MAX_YEAR_DEFAULT = 9999;

  // days in the nested leap cycles
  localparam int DAYS_400Y = 146097;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_4Y   = 1461;
  localparam int DAYS_1Y   = 365;

  localparam int YEARS_400 = 400;
  localparam int YEARS_100 = 100;
  localparam int YEARS_4   = 4;

  // quotient and remainder widths of each cycle split
  localparam int Q400_W = 5;
  localparam int R400_W = 18;
  localparam int Q100_W = 2;
  localparam int Q100_MAX = 3;
  localparam int R100_W = 16;
  localparam int Q4_W   = 5;
  localparam int Q4_MAX = 31;
  localparam int R4_W   = 11;
  localparam int Q1_W   = 2;
  localparam int DOY_W  = 9;

  // the 4-year group that holds a century year
  localparam int Q4_CENTURY = 24;
  localparam int NUM_MONTHS = 12;

  // days from 0001-01-01 through december 31 of year y
  function automatic int days_through(input int y);
    return y * DAYS_1Y + y / 4 - y / 100 + y / 400;
  endfunction

  // day of year (from zero) on which month m (from zero) begins
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] base;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m >= 4'd2) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

// ===== design/dgc_div_step.sv =====
// dgc_div_step: two-stage division by a constant using a reciprocal multiply, with side payload
`timescale 1ns / 1ps
`default_nettype none

module dgc_div_step #(
  parameter int X_W   = 22,
  parameter int D     = 146097,
  parameter int Q_W   = 5,
  parameter int Q_MAX = 31,
  parameter int R_W   = 18,
  parameter int S_W   = 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [X_W-1:0] x,
  input  wire logic [S_W-1:0] side_in,
  output logic                out_valid,
  output logic [Q_W-1:0]      quot,
  output logic [R_W-1:0]      rem,
  output logic [S_W-1:0]      side_out
);

  // exact floor division for every x below 2**X_W
  localparam int K    = X_W + $clog2(D);
  localparam int M_W  = X_W + 1;
  localparam int P_W  = X_W + M_W;
  localparam int QR_W = P_W - K;
  localparam longint unsigned RECIP_FULL = ((64'd1 << K) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [M_W-1:0] RECIP = M_W'(RECIP_FULL);

  logic [P_W-1:0]  prod;
  logic [QR_W-1:0] qraw;
  logic [Q_W-1:0]  qa_next;
  logic [X_W-1:0]  qd;

  logic            va;
  logic [X_W-1:0]  xa;
  logic [Q_W-1:0]  qa;
  logic [S_W-1:0]  sa;

  assign prod    = P_W'(x) * P_W'(RECIP);
  assign qraw    = prod[P_W-1:K];
  assign qa_next = (qraw > QR_W'(Q_MAX)) ? Q_W'(Q_MAX) : Q_W'(qraw);
  assign qd      = X_W'(qa) * X_W'(D);

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      out_valid <= va;
    end
  end

  always_ff @(posedge clk) begin
    xa       <= x;
    qa       <= qa_next;
    sa       <= side_in;
    quot     <= qa;
    rem      <= R_W'(xa - qd);
    side_out <= sa;
  end

endmodule

`default_nettype wire

// ===== design/day_count_to_gregorian_date_core.sv =====
// day_count_to_gregorian_date_core: pipelined day count to proleptic gregorian date converter
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   in:  day_count is taken at a rising edge with start high and busy low.
//        busy is high only while rst is high, so one transfer per cycle is
//        accepted back to back.
//   out: year_out, month_out, day_of_month and invalid are shown for one
//        cycle with done high; the receiver cannot hold them off.
//   pipeline: throughput is one item per cycle. A result passes the
//        input stage, then the three splits into 400-, 100- and 4-year
//        cycles, each a reciprocal multiply stage and a remainder stage,
//        then the year/day-of-year, month search and output stages.
//   invalid: a count of zero or past december 31 of MAX_YEAR gives invalid
//        high and all date fields zero.
//   reset: rst clears every valid bit; items in flight are dropped and no
//        done is raised until new transfers come through.
module day_count_to_gregorian_date_core #(
  parameter int MAX_YEAR = dgc_pkg::MAX_YEAR_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [dgc_pkg::DAY_W-1:0]   day_count,
  output logic                             done,
  output logic [dgc_pkg::YEAR_W-1:0]       year_out,
  output logic [dgc_pkg::MONTH_W-1:0]      month_out,
  output logic [dgc_pkg::DOM_W-1:0]        day_of_month,
  output logic                             invalid
);

  localparam int DAY_W   = dgc_pkg::DAY_W;
  localparam int YEAR_W  = dgc_pkg::YEAR_W;
  localparam int MONTH_W = dgc_pkg::MONTH_W;
  localparam int DOM_W   = dgc_pkg::DOM_W;
  localparam int Q400_W  = dgc_pkg::Q400_W;
  localparam int R400_W  = dgc_pkg::R400_W;
  localparam int Q100_W  = dgc_pkg::Q100_W;
  localparam int R100_W  = dgc_pkg::R100_W;
  localparam int Q4_W    = dgc_pkg::Q4_W;
  localparam int R4_W    = dgc_pkg::R4_W;
  localparam int Q1_W    = dgc_pkg::Q1_W;
  localparam int DOY_W   = dgc_pkg::DOY_W;
  localparam int S100_W  = 1 + Q400_W;
  localparam int S4_W    = S100_W + Q100_W;
  localparam int LATENCY = 10;

  localparam logic [DAY_W-1:0] LAST_DAY = DAY_W'(dgc_pkg::days_through(MAX_YEAR));

  logic transfer;
  assign busy     = rst;
  assign transfer = start && !busy;

  // stage 1: range check and zero-based index
  logic             v1;
  logic             bad1;
  logic [DAY_W-1:0] n1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= transfer;
    end
  end

  always_ff @(posedge clk) begin
    bad1 <= (day_count == '0) || (day_count > LAST_DAY);
    n1   <= day_count - DAY_W'(1);
  end

  // 400-year cycles
  logic              v3;
  logic [Q400_W-1:0] q400_3;
  logic [R400_W-1:0] r400_3;
  logic              bad3;

  dgc_div_step #(
    .X_W  (DAY_W),
    .D    (dgc_pkg::DAYS_400Y),
    .Q_W  (Q400_W),
    .Q_MAX((1 << Q400_W) - 1),
    .R_W  (R400_W),
    .S_W  (1)
  ) u_div400 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .x        (n1),
    .side_in  (bad1),
    .out_valid(v3),
    .quot     (q400_3),
    .rem      (r400_3),
    .side_out (bad3)
  );

  // 100-year cycles, the last one of four takes the leftover day
  logic              v5;
  logic [Q100_W-1:0] q100_5;
  logic [R100_W-1:0] r100_5;
  logic [S100_W-1:0] side5;

  dgc_div_step #(
    .X_W  (R400_W),
    .D    (dgc_pkg::DAYS_100Y),
    .Q_W  (Q100_W),
    .Q_MAX(dgc_pkg::Q100_MAX),
    .R_W  (R100_W),
    .S_W  (S100_W)
  ) u_div100 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .x        (r400_3),
    .side_in  ({bad3, q400_3}),
    .out_valid(v5),
    .quot     (q100_5),
    .rem      (r100_5),
    .side_out (side5)
  );

  // 4-year cycles
  logic              v7;
  logic [Q4_W-1:0]   q4_7;
  logic [R4_W-1:0]   r4_7;
  logic [S4_W-1:0]   side7;

  dgc_div_step #(
    .X_W  (R100_W),
    .D    (dgc_pkg::DAYS_4Y),
    .Q_W  (Q4_W),
    .Q_MAX(dgc_pkg::Q4_MAX),
    .R_W  (R4_W),
    .S_W  (S4_W)
  ) u_div4 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .x        (r100_5),
    .side_in  ({side5, q100_5}),
    .out_valid(v7),
    .quot     (q4_7),
    .rem      (r4_7),
    .side_out (side7)
  );

  logic              bad7;
  logic [Q400_W-1:0] q400_7;
  logic [Q100_W-1:0] q100_7;
  assign bad7   = side7[S4_W-1];
  assign q400_7 = side7[Q100_W +: Q400_W];
  assign q100_7 = side7[Q100_W-1:0];

  // stage 8: single years, year number and leap flag
  logic [Q1_W-1:0]  q1_c;
  logic [DOY_W-1:0] doy_c;
  logic             v8;
  logic             bad8;
  logic             leap8;
  logic [YEAR_W-1:0] year8;
  logic [DOY_W-1:0] doy8;

  always_comb begin
    if (r4_7 >= R4_W'(3 * dgc_pkg::DAYS_1Y)) begin
      q1_c = 2'd3;
    end else if (r4_7 >= R4_W'(2 * dgc_pkg::DAYS_1Y)) begin
      q1_c = 2'd2;
    end else if (r4_7 >= R4_W'(dgc_pkg::DAYS_1Y)) begin
      q1_c = 2'd1;
    end else begin
      q1_c = 2'd0;
    end
    doy_c = DOY_W'(r4_7 - R4_W'(q1_c) * R4_W'(dgc_pkg::DAYS_1Y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  // a year is leap when it ends a 4-year group, unless it is a century
  // year outside the fourth century of the 400-year cycle
  always_ff @(posedge clk) begin
    bad8  <= bad7;
    doy8  <= doy_c;
    leap8 <= (q1_c == 2'd3) &&
             ((q4_7 != Q4_W'(dgc_pkg::Q4_CENTURY)) ||
              (q100_7 == Q100_W'(dgc_pkg::Q100_MAX)));
    year8 <= YEAR_W'(q400_7) * YEAR_W'(dgc_pkg::YEARS_400)
           + YEAR_W'(q100_7) * YEAR_W'(dgc_pkg::YEARS_100)
           + YEAR_W'(q4_7) * YEAR_W'(dgc_pkg::YEARS_4)
           + YEAR_W'(q1_c) + YEAR_W'(1);
  end

  // stage 9: month search over the month start table
  logic [MONTH_W-1:0] mon_c;
  logic               v9;
  logic               bad9;
  logic               leap9;
  logic [YEAR_W-1:0]  year9;
  logic [DOY_W-1:0]   doy9;
  logic [MONTH_W-1:0] mon9;

  always_comb begin
    mon_c = '0;
    for (int i = 1; i < dgc_pkg::NUM_MONTHS; i++) begin
      if (doy8 >= dgc_pkg::month_start(MONTH_W'(i), leap8)) begin
        mon_c = MONTH_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    bad9  <= bad8;
    leap9 <= leap8;
    year9 <= year8;
    doy9  <= doy8;
    mon9  <= mon_c;
  end

  // stage 10: day of month and output register
  logic [DOY_W-1:0] dom_c;
  assign dom_c = doy9 - dgc_pkg::month_start(mon9, leap9) + DOY_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v9;
    end
  end

  always_ff @(posedge clk) begin
    invalid <= bad9;
    if (bad9) begin
      year_out     <= '0;
      month_out    <= '0;
      day_of_month <= '0;
    end else begin
      year_out     <= year9;
      month_out    <= mon9 + MONTH_W'(1);
      day_of_month <= DOM_W'(dom_c);
    end
  end

  // every transfer comes out after a fixed latency
  a_latency : assert property (@(posedge clk) disable iff (rst)
    transfer |-> ##LATENCY done)
    else $error("result missing after a transfer");

  // a valid date has its fields in range
  a_fields : assert property (@(posedge clk) disable iff (rst)
    (done && !invalid) |-> (year_out != '0) && (month_out >= MONTH_W'(1)) &&
      (month_out <= MONTH_W'(12)) && (day_of_month >= DOM_W'(1)))
    else $error("valid result with a field out of range");

  // february 29 only in a year divisible by four
  a_leap_day : assert property (@(posedge clk) disable iff (rst)
    (done && !invalid && month_out == MONTH_W'(2) && day_of_month == DOM_W'(29))
      |-> (year_out[1:0] == 2'b00))
    else $error("leap day in a year not divisible by four");

endmodule

`default_nettype wire

// ===== tb/sv/date_checker.sv =====
// date_checker: watches the converter ports, predicts each date and compares results in order
`timescale 1ns / 1ps
`default_nettype none

module date_checker #(
  parameter int MAX_YEAR = dgc_pkg::MAX_YEAR_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic [dgc_pkg::DAY_W-1:0]   day_count,
  input  wire logic                        done,
  input  wire logic [dgc_pkg::YEAR_W-1:0]  year_out,
  input  wire logic [dgc_pkg::MONTH_W-1:0] month_out,
  input  wire logic [dgc_pkg::DOM_W-1:0]   day_of_month,
  input  wire logic                        invalid,
  output int                               fail_count,
  output int                               pending
);

  localparam int DAY_W     = dgc_pkg::DAY_W;
  localparam int YEAR_W    = dgc_pkg::YEAR_W;
  localparam int MONTH_W   = dgc_pkg::MONTH_W;
  localparam int DOM_W     = dgc_pkg::DOM_W;
  localparam int DAYS_400Y = dgc_pkg::DAYS_400Y;
  localparam int DAYS_100Y = dgc_pkg::DAYS_100Y;
  localparam int DAYS_4Y   = dgc_pkg::DAYS_4Y;
  localparam int DAYS_1Y   = dgc_pkg::DAYS_1Y;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   dom;
    logic               inv;
  } date_t;

  // last convertible count: december 31 of MAX_YEAR
  localparam int unsigned LAST_DAY =
    MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

  date_t expected_dates[$];

  function automatic date_t to_date(input logic [DAY_W-1:0] cnt);
    date_t       d;
    int unsigned n, r, c400, c100, c4, c1, yr, mon, len;
    logic        leap;
    d = '0;
    if (cnt == 0 || cnt > LAST_DAY) begin
      d.inv = 1'b1;
      return d;
    end
    n    = cnt - 1;
    c400 = n / DAYS_400Y;
    r    = n % DAYS_400Y;
    // the last day of a 400-year cycle would give a fifth century
    c100 = r / DAYS_100Y;
    if (c100 > 3) c100 = 3;
    r    = r - c100 * DAYS_100Y;
    c4   = r / DAYS_4Y;
    r    = r % DAYS_4Y;
    c1   = r / DAYS_1Y;
    if (c1 > 3) c1 = 3;
    r    = r - c1 * DAYS_1Y;
    yr   = c400 * 400 + c100 * 100 + c4 * 4 + c1 + 1;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    mon  = 1;
    while (mon < 12) begin
      case (mon)
        2:            len = leap ? 29 : 28;
        4, 6, 9, 11:  len = 30;
        default:      len = 31;
      endcase
      if (r < len) break;
      r   = r - len;
      mon = mon + 1;
    end
    d.year  = yr[YEAR_W-1:0];
    d.month = mon[MONTH_W-1:0];
    d.dom   = r[DOM_W-1:0] + 1'b1;
    return d;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count = fail_count + 1;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    date_t want;
    if (!rst) begin
      // compare before taking the new transfer, so a result never meets its own item
      if (done) begin
        if (expected_dates.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = expected_dates.pop_front();
          if (year_out !== want.year)
            report("year_out", int'(year_out), int'(want.year));
          if (month_out !== want.month)
            report("month_out", int'(month_out), int'(want.month));
          if (day_of_month !== want.dom)
            report("day_of_month", int'(day_of_month), int'(want.dom));
          if (invalid !== want.inv)
            report("invalid", int'(invalid), int'(want.inv));
        end
      end
      if (start && !busy) begin
        expected_dates.push_back(to_date(day_count));
      end
    end
    pending = expected_dates.size();
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: drives day counts into the date converter and gives the verdict
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int DAY_W            = dgc_pkg::DAY_W;
  localparam int YEAR_W           = dgc_pkg::YEAR_W;
  localparam int MONTH_W          = dgc_pkg::MONTH_W;
  localparam int DOM_W            = dgc_pkg::DOM_W;
  localparam int MAX_YEAR_DEFAULT = dgc_pkg::MAX_YEAR_DEFAULT;

  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_LIMIT  = 2000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [DAY_W-1:0]   day_count;
  logic               done;
  logic [YEAR_W-1:0]  year_out;
  logic [MONTH_W-1:0] month_out;
  logic [DOM_W-1:0]   day_of_month;
  logic               invalid;
  int                 fail_count;
  int                 pending;

  day_count_to_gregorian_date_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .day_count    (day_count),
    .done         (done),
    .year_out     (year_out),
    .month_out    (month_out),
    .day_of_month (day_of_month),
    .invalid      (invalid)
  );

  date_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .day_count    (day_count),
    .done         (done),
    .year_out     (year_out),
    .month_out    (month_out),
    .day_of_month (day_of_month),
    .invalid      (invalid),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // days from 0001-01-01 through december 31 of year y
  function automatic int unsigned year_end_day(input int unsigned y);
    return y * 365 + y / 4 - y / 100 + y / 400;
  endfunction

  function automatic logic [DAY_W-1:0] pick_day_count();
    int unsigned base;
    int unsigned pick;
    int unsigned val;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      val = $urandom_range(1, year_end_day(MAX_YEAR_DEFAULT));
    end else if (pick == 6) begin
      val = $urandom_range(0, 3000);
    end else if (pick == 7) begin
      // land on month and year edges of a random year
      base = year_end_day($urandom_range(1, MAX_YEAR_DEFAULT) - 1);
      case ($urandom_range(0, 5))
        0:       val = base + 1;
        1:       val = base + 59;
        2:       val = base + 60;
        3:       val = base + 61;
        4:       val = base + 365;
        default: val = base + 366;
      endcase
    end else begin
      val = $urandom();
    end
    return DAY_W'(val);
  endfunction

  // hold start high until the transfer is taken
  task automatic send_count(input logic [DAY_W-1:0] cnt);
    start     <= 1'b1;
    day_count <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    #2ms;
    $display("day_count_to_gregorian_date_core regression: fail");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    int gap;
    int waited;
    bit paused;
    rst       <= 1'b1;
    start     <= 1'b0;
    day_count <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_count(22'd0);                       // zero count
    send_count(22'd1);                       // 0001-01-01
    send_count(22'd59);                      // 0001-02-28
    send_count(22'd60);                      // 0001-03-01
    send_count(22'd365);                     // 0001-12-31
    send_count(22'd366);                     // 0002-01-01
    send_count(22'd1155);                    // 0004-02-29
    send_count(22'd1460);
    send_count(22'd1461);                    // 0004-12-31
    send_count(22'd36218);                   // 0100-02-28, century not leap
    send_count(22'd36219);                   // 0100-03-01
    send_count(22'd36524);
    send_count(22'd36525);
    send_count(22'd146096);
    send_count(22'd146097);                  // 0400-12-31
    send_count(22'd146098);
    send_count(22'd730179);                  // 2000-02-29
    send_count(DAY_W'(year_end_day(MAX_YEAR_DEFAULT)));     // last valid day
    send_count(DAY_W'(year_end_day(MAX_YEAR_DEFAULT) + 1)); // just past the limit
    send_count(22'h3FFFFF);
    send_count(22'h2AAAAA);
    send_count(22'h155555);
    drain();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_count(pick_day_count());
        sent++;
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end else begin
        // some bursts run straight into the next one
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    start  <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending != 0) begin
      $display("day_count_to_gregorian_date_core regression: fail");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      if (fail_count == 0) begin
        $display("day_count_to_gregorian_date_core regression: pass");
      end else begin
        $display("day_count_to_gregorian_date_core regression: fail");
      end
      $finish;
    end
  end

endmodule

`default_nettype wire
